[rtl/aabb_broad_phase_pairs_macros.svh]
// Assertion macros shared by the broad-phase pair block.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef AABB_BROAD_PHASE_PAIRS_MACROS_SVH
`define AABB_BROAD_PHASE_PAIRS_MACROS_SVH

// Same-cycle implication.
`define ABPP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("abpp: same-cycle check failed");

// Next-cycle implication.
`define ABPP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("abpp: next-cycle check failed");

`endif

[rtl/abpp_pkg.sv]
`timescale 1ns / 1ps

package abpp_pkg;

    localparam int MAX_ENTITIES = 8;
    localparam int COORD_BITS   = 32;

    localparam int IDX_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTITIES);

    typedef struct packed {
        logic signed [31:0] lo_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] lo_z;
        logic signed [31:0] hi_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] hi_z;
        logic               is_empty;
        logic               may_collide;
        logic               is_stable;
        logic               last_entity;
    } t_req;

    typedef struct packed {
        logic       pair_valid;
        logic [2:0] index_a;
        logic [2:0] index_b;
        logic       a_moves;
        logic       b_moves;
        logic       last_pair;
    } t_result;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] lo_x;
        logic signed [COORD_BITS-1:0] lo_y;
        logic signed [COORD_BITS-1:0] lo_z;
        logic signed [COORD_BITS-1:0] hi_x;
        logic signed [COORD_BITS-1:0] hi_y;
        logic signed [COORD_BITS-1:0] hi_z;
        logic                         is_empty;
        logic                         may_collide;
        logic                         is_stable;
    } t_box;

    typedef struct packed {
        logic load;
        logic sweep_init;
        logic sweep;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

    // Sign-extend or truncate a 32-bit coordinate to the stored width.
    function automatic logic signed [COORD_BITS-1:0] take_coord(logic signed [31:0] v);
        logic signed [COORD_BITS+31:0] w;
        w = (COORD_BITS + 32)'(v);
        return w[COORD_BITS-1:0];
    endfunction

    // Result indexes keep their low three bits.
    function automatic logic [2:0] idx3(logic [IDX_W-1:0] v);
        logic [IDX_W+2:0] w;
        w = (IDX_W + 3)'(v);
        return w[2:0];
    endfunction

endpackage

[rtl/aabb_broad_phase_pairs.sv]
`timescale 1ns / 1ps
// Loading accepts a box with each request while idle and returns nothing; busy stays low while boxes load.
// After the box marked last, the block tests one pair per cycle from its box memory,
// staying busy until every pair of the N boxes held has been tested.
// Results leave on one-cycle strobes that the receiver cannot stall; the final result
// is strobed in the first cycle with busy low, when the next request can already enter.
// Reset is synchronous and active low: it empties the box set and clears all strobes.

`include "aabb_broad_phase_pairs_macros.svh"

module aabb_broad_phase_pairs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  abpp_pkg::t_req    i_req,
    output logic              o_busy,
    output logic              o_valid,
    output abpp_pkg::t_result o_result
);

    // The controller decodes request acceptance and walks the pair sweep; the datapath
    // owns the box memory, the pair counters, the compare stage and the result register.
    abpp_pkg::t_cmd    w_cmd;
    abpp_pkg::t_status w_status;

    abpp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_last   (i_req.last_entity),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_busy)
    );

    // Each sweep cycle reads two boxes; the next cycle compares them. A qualifying pair
    // waits in a holding register until either another pair or the end of the sweep
    // decides whether it is the last one of the set.
    abpp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_req    (i_req),
        .o_status (w_status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // An empty result only ever closes a set.
    `ABPP_ASSERT_IMP(a_empty_is_last, o_valid && !o_result.pair_valid, o_result.last_pair)
    // A reported pair always has at least one moving member.
    `ABPP_ASSERT_IMP(a_pair_moves, o_valid && o_result.pair_valid,
                     o_result.a_moves || o_result.b_moves)
    // Accepting the closing request starts the sweep.
    `ABPP_ASSERT_NXT(a_last_starts, i_start && !o_busy && i_req.last_entity, o_busy)
    // The final result of a set is never followed at once by another result.
    `ABPP_ASSERT_NXT(a_last_gap, o_valid && o_result.last_pair, !o_valid)

endmodule

[rtl/abpp_ctrl.sv]
`timescale 1ns / 1ps

module abpp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last,
    input  abpp_pkg::t_status i_status,
    output abpp_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == ST_IDLE) && i_start;
        o_cmd.sweep_init = o_cmd.load && i_last;
        o_cmd.sweep      = (r_state == ST_SWEEP);
        o_cmd.finish     = o_cmd.sweep && i_status.done;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.sweep_init) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (o_cmd.finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_busy = (n_state == ST_SWEEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

[rtl/abpp_dp.sv]
`timescale 1ns / 1ps

module abpp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  abpp_pkg::t_cmd     i_cmd,
    input  abpp_pkg::t_req     i_req,
    output abpp_pkg::t_status  o_status,
    output logic               o_valid,
    output abpp_pkg::t_result  o_result
);

    localparam int IDX_W = abpp_pkg::IDX_W;
    localparam int CNT_W = abpp_pkg::CNT_W;

    abpp_pkg::t_box    r_mem [abpp_pkg::MAX_ENTITIES];
    abpp_pkg::t_box    r_box_a, r_box_b;
    abpp_pkg::t_box    w_box;
    abpp_pkg::t_result r_pend, r_out, w_pair, w_final;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_a, r_b;
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_a, r_s1_b;
    logic             r_pend_valid;
    logic             r_out_valid;

    logic w_issue_ok;
    logic w_write;
    logic w_overlap;
    logic w_qualify;

    always_comb begin
        w_box.lo_x        = abpp_pkg::take_coord(i_req.lo_x);
        w_box.lo_y        = abpp_pkg::take_coord(i_req.lo_y);
        w_box.lo_z        = abpp_pkg::take_coord(i_req.lo_z);
        w_box.hi_x        = abpp_pkg::take_coord(i_req.hi_x);
        w_box.hi_y        = abpp_pkg::take_coord(i_req.hi_y);
        w_box.hi_z        = abpp_pkg::take_coord(i_req.hi_z);
        w_box.is_empty    = i_req.is_empty;
        w_box.may_collide = i_req.may_collide;
        w_box.is_stable   = i_req.is_stable;
    end

    assign w_write    = i_cmd.load && (r_count < abpp_pkg::MAX_CNT);
    assign w_issue_ok = (r_b < r_count);
    assign o_status.done = !w_issue_ok && !r_s1_valid;

    // Box memory: one write port for loading, two registered read ports for the sweep.
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_count[IDX_W-1:0]] <= w_box;
        end
        if (i_cmd.sweep && w_issue_ok) begin
            r_box_a <= r_mem[r_a[IDX_W-1:0]];
            r_box_b <= r_mem[r_b[IDX_W-1:0]];
        end
    end

    // Strict overlap on all three axes, then the flag rules.
    always_comb begin
        w_overlap = ($signed(r_box_a.lo_x) < $signed(r_box_b.hi_x))
                 && ($signed(r_box_b.lo_x) < $signed(r_box_a.hi_x))
                 && ($signed(r_box_a.lo_y) < $signed(r_box_b.hi_y))
                 && ($signed(r_box_b.lo_y) < $signed(r_box_a.hi_y))
                 && ($signed(r_box_a.lo_z) < $signed(r_box_b.hi_z))
                 && ($signed(r_box_b.lo_z) < $signed(r_box_a.hi_z));
        w_qualify = r_s1_valid
                 && !r_box_a.is_empty && !r_box_b.is_empty
                 && r_box_a.may_collide && r_box_b.may_collide
                 && !(r_box_a.is_stable && r_box_b.is_stable)
                 && w_overlap;

        w_pair            = '0;
        w_pair.pair_valid = 1'b1;
        w_pair.index_a    = abpp_pkg::idx3(r_s1_a);
        w_pair.index_b    = abpp_pkg::idx3(r_s1_b);
        w_pair.a_moves    = !r_box_a.is_stable;
        w_pair.b_moves    = !r_box_b.is_stable;

        if (r_pend_valid) begin
            w_final = r_pend;
        end else begin
            w_final = '0;
        end
        w_final.last_pair = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_a          <= '0;
            r_b          <= '0;
            r_s1_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.finish || (w_qualify && r_pend_valid);
            r_s1_valid  <= i_cmd.sweep && w_issue_ok;

            if (w_write) begin
                r_count <= r_count + CNT_W'(1);
            end

            if (i_cmd.sweep_init) begin
                r_a <= '0;
                r_b <= CNT_W'(1);
            end else if (i_cmd.sweep && w_issue_ok) begin
                r_s1_a     <= r_a[IDX_W-1:0];
                r_s1_b     <= r_b[IDX_W-1:0];
                if ((r_b + CNT_W'(1)) < r_count) begin
                    r_b <= r_b + CNT_W'(1);
                end else begin
                    r_a <= r_a + CNT_W'(1);
                    r_b <= r_a + CNT_W'(2);
                end
            end

            // A pair is held back until the next pair arrives so the final one can carry the last mark.
            if (w_qualify) begin
                r_pend       <= w_pair;
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out       <= r_pend;
                end
            end

            if (i_cmd.finish) begin
                r_out        <= w_final;
                r_pend_valid <= 1'b0;
                r_count      <= '0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
